/* design/lpd_pkg.sv */
// Package for the length-prefixed deframer: request and response payload types,
// parser modes, status codes, character constants and the queue entry type.
// No dependencies.
package lpd_pkg;

   localparam int SIZE_DIGIT_LIMIT = 6;
   localparam int MAX_MESSAGE_LEN  = 65536;
   localparam int QUEUE_DEPTH      = 4;

   localparam logic [7:0]  CH_OPEN        = 8'h7B;
   localparam logic [7:0]  CH_CLOSE       = 8'h7D;
   localparam logic [7:0]  CH_ZERO        = 8'h30;
   localparam logic [7:0]  CH_NINE        = 8'h39;
   localparam logic [16:0] SIZE_MAX_VALUE = 17'd65535;

   typedef enum logic [1:0] {
      MODE_IDLE    = 2'd0,
      MODE_SIZE    = 2'd1,
      MODE_PAYLOAD = 2'd2,
      MODE_ERROR   = 2'd3
   } mode_type;

   typedef enum logic [1:0] {
      STATUS_OK     = 2'd0,
      STATUS_DIGITS = 2'd1,
      STATUS_SIZE   = 2'd2,
      STATUS_SYNTAX = 2'd3
   } status_type;

   localparam logic KIND_PAYLOAD = 1'b0;
   localparam logic KIND_STATUS  = 1'b1;

   typedef struct packed {
      logic [7:0] data_byte;
      logic       end_of_message;
   } req_type;

   typedef struct packed {
      logic        kind;
      logic [7:0]  payload_byte;
      logic        entry_last;
      logic [1:0]  status_code;
      logic [15:0] error_offset;
   } rsp_type;

   typedef struct packed {
      logic        has_data;
      logic [7:0]  data_byte;
      logic        entry_last;
      logic        has_status;
      status_type  status_code;
      logic [15:0] error_offset;
   } cmd_type;

endpackage

/* design/lpd_front.sv */
// Front end of the deframer: accepts request bytes, runs the size-spec parser
// and writes one command per productive byte into the queue. Uses lpd_pkg.
module lpd_front #(
   parameter int SIZE_DIGIT_LIMIT = lpd_pkg::SIZE_DIGIT_LIMIT,
   parameter int MAX_MESSAGE_LEN  = lpd_pkg::MAX_MESSAGE_LEN
) (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_valid,
   input  lpd_pkg::req_type  req_data,
   input  logic              queue_full,
   output logic              req_stall,
   output logic              cmd_write,
   output lpd_pkg::cmd_type  cmd_data,
   output lpd_pkg::mode_type parse_mode
);

   localparam logic [2:0]  DIGIT_LIMIT = 3'(SIZE_DIGIT_LIMIT);
   localparam logic [15:0] POS_MAX     = 16'(MAX_MESSAGE_LEN - 1);

   lpd_pkg::mode_type   mode_ff, mode_in;
   logic [16:0]         size_ff, size_in;
   logic [2:0]          count_ff, count_in;
   logic [15:0]         remain_ff, remain_in;
   logic [15:0]         pos_ff, pos_in;
   lpd_pkg::status_type err_code_ff, err_code_in;
   logic [15:0]         err_pos_ff, err_pos_in;

   logic       accept;
   logic [7:0] ch;
   logic [2:0] count_inc;
   logic       is_digit;

   assign req_stall  = queue_full;
   assign accept     = req_valid && !queue_full;
   assign ch         = req_data.data_byte;
   assign is_digit   = (ch >= lpd_pkg::CH_ZERO) && (ch <= lpd_pkg::CH_NINE);
   assign count_inc  = count_ff + 3'd1;
   assign parse_mode = mode_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff     <= lpd_pkg::MODE_IDLE;
         size_ff     <= '0;
         count_ff    <= '0;
         remain_ff   <= '0;
         pos_ff      <= '0;
         err_code_ff <= lpd_pkg::STATUS_OK;
         err_pos_ff  <= '0;
      end else if (accept) begin
         mode_ff     <= mode_in;
         size_ff     <= size_in;
         count_ff    <= count_in;
         remain_ff   <= remain_in;
         pos_ff      <= pos_in;
         err_code_ff <= err_code_in;
         err_pos_ff  <= err_pos_in;
      end
   end

   always_comb begin
      mode_in     = mode_ff;
      size_in     = size_ff;
      count_in    = count_ff;
      remain_in   = remain_ff;
      err_code_in = err_code_ff;
      err_pos_in  = err_pos_ff;
      cmd_data    = '0;

      unique case (mode_ff)
         lpd_pkg::MODE_IDLE: begin
            if (ch == lpd_pkg::CH_OPEN) begin
               mode_in  = lpd_pkg::MODE_SIZE;
               size_in  = '0;
               count_in = '0;
            end
         end
         lpd_pkg::MODE_SIZE: begin
            if (ch == lpd_pkg::CH_OPEN) begin
               size_in  = '0;
               count_in = '0;
            end else if (is_digit) begin
               count_in = count_inc;
               if (count_inc >= DIGIT_LIMIT) begin
                  mode_in     = lpd_pkg::MODE_ERROR;
                  err_code_in = lpd_pkg::STATUS_DIGITS;
                  err_pos_in  = '0;
               end else begin
                  size_in = 17'(size_ff * 17'd10 + 17'(ch - lpd_pkg::CH_ZERO));
               end
            end else if (ch == lpd_pkg::CH_CLOSE) begin
               if (count_ff == 3'd0 || size_ff > lpd_pkg::SIZE_MAX_VALUE) begin
                  mode_in     = lpd_pkg::MODE_ERROR;
                  err_code_in = lpd_pkg::STATUS_SIZE;
                  err_pos_in  = '0;
               end else begin
                  remain_in = (size_ff == 17'd0) ? 16'd1 : size_ff[15:0];
                  mode_in   = lpd_pkg::MODE_PAYLOAD;
                  size_in   = '0;
                  count_in  = '0;
               end
            end else begin
               mode_in     = lpd_pkg::MODE_ERROR;
               err_code_in = lpd_pkg::STATUS_SYNTAX;
               err_pos_in  = pos_ff;
            end
         end
         lpd_pkg::MODE_PAYLOAD: begin
            cmd_data.has_data  = 1'b1;
            cmd_data.data_byte = ch;
            if (remain_ff <= 16'd1) begin
               cmd_data.entry_last = 1'b1;
               remain_in           = '0;
               mode_in             = lpd_pkg::MODE_IDLE;
            end else begin
               remain_in = remain_ff - 16'd1;
            end
         end
         lpd_pkg::MODE_ERROR: begin
         end
         default: begin
         end
      endcase

      pos_in = (pos_ff < POS_MAX) ? pos_ff + 16'd1 : pos_ff;

      if (req_data.end_of_message) begin
         cmd_data.has_status   = 1'b1;
         cmd_data.status_code  = err_code_in;
         cmd_data.error_offset =
            (err_code_in == lpd_pkg::STATUS_SYNTAX) ? err_pos_in : 16'd0;
         mode_in     = lpd_pkg::MODE_IDLE;
         size_in     = '0;
         count_in    = '0;
         remain_in   = '0;
         pos_in      = '0;
         err_code_in = lpd_pkg::STATUS_OK;
         err_pos_in  = '0;
      end

      cmd_write = accept && (cmd_data.has_data || cmd_data.has_status);
   end

endmodule

/* design/lpd_queue.sv */
// Command queue between the parser front end and the response back end.
// Small register array with head and tail pointers. Uses lpd_pkg.
module lpd_queue #(
   parameter int DEPTH = lpd_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             wr_en,
   input  lpd_pkg::cmd_type wr_data,
   input  logic             rd_en,
   output lpd_pkg::cmd_type rd_data,
   output logic             full,
   output logic             empty
);

   localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam logic [AW-1:0] LAST_PTR = AW'(DEPTH - 1);
   localparam logic [AW:0]   FULL_CNT = (AW + 1)'(DEPTH);

   lpd_pkg::cmd_type mem_ff [DEPTH];
   logic [AW-1:0]    wr_ptr_ff, wr_ptr_in;
   logic [AW-1:0]    rd_ptr_ff, rd_ptr_in;
   logic [AW:0]      count_ff, count_in;
   logic             do_wr, do_rd;

   assign full    = (count_ff == FULL_CNT);
   assign empty   = (count_ff == '0);
   assign do_wr   = wr_en && !full;
   assign do_rd   = rd_en && !empty;
   assign rd_data = mem_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = wr_ptr_ff;
      rd_ptr_in = rd_ptr_ff;
      count_in  = count_ff;
      if (do_wr) begin
         wr_ptr_in = (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + AW'(1);
      end
      if (do_rd) begin
         rd_ptr_in = (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + AW'(1);
      end
      if (do_wr && !do_rd) begin
         count_in = count_ff + (AW + 1)'(1);
      end else if (do_rd && !do_wr) begin
         count_in = count_ff - (AW + 1)'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_wr) begin
         mem_ff[wr_ptr_ff] <= wr_data;
      end
   end

endmodule

/* design/lpd_back.sv */
// Back end of the deframer: pops queued commands and expands each into one or
// two response items through a registered output stage. Uses lpd_pkg.
module lpd_back (
   input  logic             clock,
   input  logic             reset,
   input  lpd_pkg::cmd_type cmd_data,
   input  logic             cmd_empty,
   output logic             cmd_read,
   output logic             rsp_valid,
   output lpd_pkg::rsp_type rsp_data,
   input  logic             rsp_stall,
   output logic             pend_valid
);

   logic             rsp_valid_ff, rsp_valid_in;
   lpd_pkg::rsp_type rsp_ff, rsp_in;
   logic             pend_ff, pend_in;
   lpd_pkg::rsp_type status_ff, status_in;
   lpd_pkg::rsp_type cmd_status;
   logic             slot_free;

   assign slot_free  = !rsp_valid_ff || !rsp_stall;
   assign cmd_read   = slot_free && !pend_ff && !cmd_empty;
   assign rsp_valid  = rsp_valid_ff;
   assign rsp_data   = rsp_ff;
   assign pend_valid = pend_ff;

   always_comb begin
      cmd_status              = '0;
      cmd_status.kind         = lpd_pkg::KIND_STATUS;
      cmd_status.status_code  = cmd_data.status_code;
      cmd_status.error_offset = cmd_data.error_offset;

      rsp_valid_in = rsp_valid_ff;
      rsp_in       = rsp_ff;
      pend_in      = pend_ff;
      status_in    = status_ff;

      if (slot_free) begin
         rsp_valid_in = 1'b0;
         if (pend_ff) begin
            rsp_valid_in = 1'b1;
            rsp_in       = status_ff;
            pend_in      = 1'b0;
         end else if (!cmd_empty) begin
            rsp_valid_in = 1'b1;
            if (cmd_data.has_data) begin
               rsp_in              = '0;
               rsp_in.kind         = lpd_pkg::KIND_PAYLOAD;
               rsp_in.payload_byte = cmd_data.data_byte;
               rsp_in.entry_last   = cmd_data.entry_last;
               pend_in             = cmd_data.has_status;
               status_in           = cmd_status;
            end else begin
               rsp_in = cmd_status;
            end
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
         pend_ff      <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
         pend_ff      <= pend_in;
      end
   end

   always_ff @(posedge clock) begin
      rsp_ff    <= rsp_in;
      status_ff <= status_in;
   end

endmodule

/* design/length_prefixed_deframer_core.sv */
// Length-prefixed message deframer, top level.
// Request channel (req_valid, req_stall, req_data) takes one message byte per
// request, with end_of_message set on the final byte. Entries in the message
// are '{' decimal size '}' followed by that many payload bytes (one for size 0).
// Response channel (rsp_valid, rsp_stall, rsp_data) carries one payload byte per
// response (kind 0, entry_last on the final byte of an entry) and, after the
// final byte of a message, one status response (kind 1) with the status code
// and, for a syntax error, the byte offset.
// Commands from accepted bytes go into the command queue; their responses leave
// through the registered output stage. Throughput: one request per cycle while
// the queue is not full; a final byte that is also a payload byte yields two
// responses, sent one after the other. The parser steps once per accepted byte;
// the command queue (QUEUE_DEPTH entries) decouples it from the output stage.
// Reset clears parser state, queue and output valid; no request is stalled
// after reset except while the queue is full.
// A stalled response holds; the queue absorbs bytes until it fills, then
// req_stall rises.
// Depends on lpd_pkg, lpd_front, lpd_queue and lpd_back.
module length_prefixed_deframer_core #(
   parameter int SIZE_DIGIT_LIMIT = lpd_pkg::SIZE_DIGIT_LIMIT,
   parameter int MAX_MESSAGE_LEN  = lpd_pkg::MAX_MESSAGE_LEN,
   parameter int QUEUE_DEPTH      = lpd_pkg::QUEUE_DEPTH
) (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   output logic             req_stall,
   input  lpd_pkg::req_type req_data,
   output logic             rsp_valid,
   input  logic             rsp_stall,
   output lpd_pkg::rsp_type rsp_data
);

   logic              q_full, q_empty;
   logic              q_write, q_read;
   lpd_pkg::cmd_type  q_wr_data, q_rd_data;
   lpd_pkg::mode_type parse_mode;
   logic              pend_valid;

   lpd_front #(
      .SIZE_DIGIT_LIMIT(SIZE_DIGIT_LIMIT),
      .MAX_MESSAGE_LEN (MAX_MESSAGE_LEN)
   ) u_front (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_data  (req_data),
      .queue_full(q_full),
      .req_stall (req_stall),
      .cmd_write (q_write),
      .cmd_data  (q_wr_data),
      .parse_mode(parse_mode)
   );

   lpd_queue #(
      .DEPTH(QUEUE_DEPTH)
   ) u_queue (
      .clock  (clock),
      .reset  (reset),
      .wr_en  (q_write),
      .wr_data(q_wr_data),
      .rd_en  (q_read),
      .rd_data(q_rd_data),
      .full   (q_full),
      .empty  (q_empty)
   );

   lpd_back u_back (
      .clock     (clock),
      .reset     (reset),
      .cmd_data  (q_rd_data),
      .cmd_empty (q_empty),
      .cmd_read  (q_read),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .rsp_stall (rsp_stall),
      .pend_valid(pend_valid)
   );

   a_pend_has_output: assert property (@(posedge clock) disable iff (reset)
      pend_valid |-> rsp_valid)
      else $error("pending status without a response in the output stage");

   a_reset_clears_output: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("response valid after reset");

   a_eom_returns_idle: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall && req_data.end_of_message)
         |=> (parse_mode == lpd_pkg::MODE_IDLE))
      else $error("parser not idle after final byte of message");

endmodule

/* dv/length_prefixed_deframer_checker.sv */
// Response checker for length_prefixed_deframer_core: predicts the payload and status
// responses of each accepted request byte and compares them in order.
// Depends on lpd_pkg.
`timescale 1ns / 1ps

module length_prefixed_deframer_checker (
   input  logic             clock,
   input  logic             reset,
   input  logic             req_valid,
   input  logic             req_stall,
   input  lpd_pkg::req_type req_data,
   input  logic             rsp_valid,
   input  logic             rsp_stall,
   input  lpd_pkg::rsp_type rsp_data,
   output int               mismatch_count,
   output int               responses_due
);

   lpd_pkg::rsp_type    due_responses[$];
   lpd_pkg::mode_type   mode;
   logic [16:0]         size_acc;
   logic [2:0]          digits;
   logic [15:0]         remaining;
   logic [15:0]         position;
   lpd_pkg::status_type first_status;
   logic [15:0]         status_offset;

   task automatic clear_parser();
      mode          = lpd_pkg::MODE_IDLE;
      size_acc      = '0;
      digits        = '0;
      remaining     = '0;
      position      = '0;
      first_status  = lpd_pkg::STATUS_OK;
      status_offset = '0;
   endtask

   task automatic flag_status(input lpd_pkg::status_type code);
      mode          = lpd_pkg::MODE_ERROR;
      first_status  = code;
      status_offset = (code == lpd_pkg::STATUS_SYNTAX) ? position : 16'd0;
   endtask

   function automatic string show(input lpd_pkg::rsp_type r);
      return $sformatf("kind=%0d byte=%02h last=%0d status=%0d offset=%0d",
                       r.kind, r.payload_byte, r.entry_last, r.status_code,
                       r.error_offset);
   endfunction

   task automatic report(input string what, input lpd_pkg::rsp_type got,
                         input lpd_pkg::rsp_type want);
      $display("ERROR %0t: %s: got %s, expected %s", $time, what, show(got), show(want));
      mismatch_count++;
   endtask

   task automatic deframe_byte(input lpd_pkg::req_type r);
      lpd_pkg::rsp_type out;
      logic [7:0]       ch;
      ch  = r.data_byte;
      out = '0;
      case (mode)
         lpd_pkg::MODE_IDLE: begin
            if (ch == lpd_pkg::CH_OPEN) begin
               mode     = lpd_pkg::MODE_SIZE;
               size_acc = '0;
               digits   = '0;
            end
         end
         lpd_pkg::MODE_SIZE: begin
            if (ch == lpd_pkg::CH_OPEN) begin
               size_acc = '0;
               digits   = '0;
            end else if (ch >= lpd_pkg::CH_ZERO && ch <= lpd_pkg::CH_NINE) begin
               digits = digits + 3'd1;
               if (digits >= lpd_pkg::SIZE_DIGIT_LIMIT)
                  flag_status(lpd_pkg::STATUS_DIGITS);
               else
                  size_acc = size_acc * 17'd10 + {9'd0, ch - lpd_pkg::CH_ZERO};
            end else if (ch == lpd_pkg::CH_CLOSE) begin
               if (digits == 3'd0 || size_acc > lpd_pkg::SIZE_MAX_VALUE) begin
                  flag_status(lpd_pkg::STATUS_SIZE);
               end else begin
                  remaining = (size_acc == '0) ? 16'd1 : size_acc[15:0];
                  mode      = lpd_pkg::MODE_PAYLOAD;
                  size_acc  = '0;
                  digits    = '0;
               end
            end else begin
               flag_status(lpd_pkg::STATUS_SYNTAX);
            end
         end
         lpd_pkg::MODE_PAYLOAD: begin
            out.kind         = lpd_pkg::KIND_PAYLOAD;
            out.payload_byte = ch;
            out.entry_last   = (remaining <= 16'd1);
            due_responses.push_back(out);
            if (remaining <= 16'd1) begin
               remaining = '0;
               mode      = lpd_pkg::MODE_IDLE;
            end else begin
               remaining = remaining - 16'd1;
            end
         end
         default: ;
      endcase
      if (position < 16'(lpd_pkg::MAX_MESSAGE_LEN - 1))
         position = position + 16'd1;
      if (r.end_of_message) begin
         out              = '0;
         out.kind         = lpd_pkg::KIND_STATUS;
         out.status_code  = first_status;
         out.error_offset =
            (first_status == lpd_pkg::STATUS_SYNTAX) ? status_offset : 16'd0;
         due_responses.push_back(out);
         clear_parser();
      end
   endtask

   always @(posedge clock) begin
      lpd_pkg::rsp_type want;
      if (reset) begin
         clear_parser();
         due_responses.delete();
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (due_responses.size() == 0) begin
               report("unexpected response", rsp_data, '0);
            end else begin
               want = due_responses.pop_front();
               if (rsp_data.kind !== want.kind ||
                   rsp_data.payload_byte !== want.payload_byte ||
                   rsp_data.entry_last !== want.entry_last ||
                   rsp_data.status_code !== want.status_code ||
                   rsp_data.error_offset !== want.error_offset)
                  report("response mismatch", rsp_data, want);
            end
         end
         if (req_valid && !req_stall)
            deframe_byte(req_data);
      end
      responses_due = due_responses.size();
   end

endmodule

/* dv/length_prefixed_deframer_core_tb.sv */
// Testbench top for length_prefixed_deframer_core: builds directed and random
// messages, paces requests and response stalls, and gives the verdict.
// Depends on lpd_pkg, length_prefixed_deframer_core and length_prefixed_deframer_checker.
`timescale 1ns / 1ps

module length_prefixed_deframer_core_tb;

   localparam int CYCLE_LIMIT  = 200_000;
   localparam int RANDOM_BYTES = 580;

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   lpd_pkg::req_type req_data  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   lpd_pkg::rsp_type rsp_data;

   int         mismatch_count;
   int         responses_due;
   int         cycle_count;
   int         burst_left;
   int         bytes_sent;
   int         stall_mode;
   int         stall_left;
   logic [7:0] message[$];

   length_prefixed_deframer_core u_top (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_data  (req_data),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_data  (rsp_data)
   );

   length_prefixed_deframer_checker u_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_data       (req_data),
      .rsp_valid      (rsp_valid),
      .rsp_stall      (rsp_stall),
      .rsp_data       (rsp_data),
      .mismatch_count (mismatch_count),
      .responses_due  (responses_due)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin
      cycle_count <= cycle_count + 1;
      if (cycle_count >= CYCLE_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end
   end

   always @(posedge clock) begin
      if (stall_left == 0) begin
         stall_mode <= $urandom_range(0, 3);
         stall_left <= $urandom_range(8, 80);
      end else begin
         stall_left <= stall_left - 1;
      end
      case (stall_mode)
         0:       rsp_stall <= 1'b0;
         1:       rsp_stall <= ($urandom_range(0, 3) == 0);
         2:       rsp_stall <= ($urandom_range(0, 3) != 0);
         default: rsp_stall <= ((stall_left % 5) < 2);
      endcase
   end

   function automatic logic [7:0] noise_byte();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (b == lpd_pkg::CH_OPEN);
      return b;
   endfunction

   task automatic push_text(input string s);
      int i;
      for (i = 0; i < s.len(); i++)
         message.push_back(s[i]);
   endtask

   task automatic send_request(input logic [7:0] b, input logic eom);
      int gap;
      if (burst_left == 0) begin
         gap = ($urandom_range(0, 7) == 0) ? $urandom_range(5, 20) : $urandom_range(0, 3);
         burst_left = ($urandom_range(0, 9) == 0) ? $urandom_range(50, 200)
                                                   : $urandom_range(1, 24);
         if (gap > 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid <= 1'b1;
      req_data  <= '{data_byte: b, end_of_message: eom};
      do @(posedge clock); while (req_stall);
      bytes_sent++;
   endtask

   task automatic send_message();
      int i;
      for (i = 0; i < message.size(); i++)
         send_request(message[i], i == message.size() - 1);
      message.delete();
   endtask

   task automatic add_entry();
      int         shape;
      int         size;
      logic [7:0] b;
      shape = $urandom_range(0, 29);
      repeat ($urandom_range(0, 2)) message.push_back(noise_byte());
      message.push_back(lpd_pkg::CH_OPEN);
      if (shape == 0) begin
         push_text($sformatf("%0d", $urandom_range(0, 99)));
         message.push_back(lpd_pkg::CH_OPEN);
      end
      case (shape)
         1: push_text($sformatf("%06d}", $urandom_range(0, 999999)));
         2: message.push_back(lpd_pkg::CH_CLOSE);
         3: push_text($sformatf("%0d}", $urandom_range(0, 1) ? 65536
                                                             : $urandom_range(65536, 99999)));
         4: begin
            if ($urandom_range(0, 1))
               push_text($sformatf("%0d", $urandom_range(0, 999)));
            do b = 8'($urandom_range(0, 255));
            while ((b >= lpd_pkg::CH_ZERO && b <= lpd_pkg::CH_NINE) ||
                   b == lpd_pkg::CH_OPEN || b == lpd_pkg::CH_CLOSE);
            message.push_back(b);
         end
         default: begin
            size = (shape < 8) ? $urandom_range(13, 60) : $urandom_range(0, 12);
            if (shape == 5)
               push_text("0");
            push_text($sformatf("%0d}", size));
            repeat ((size == 0) ? 1 : size) message.push_back(8'($urandom_range(0, 255)));
         end
      endcase
   endtask

   initial begin
      int target;
      int keep;
      int cut;
      repeat (2) @(posedge clock);
      reset <= 1'b0;

      push_text("{0}");
      message.push_back(8'h00);
      push_text("{2}");
      message.push_back(8'hFF);
      message.push_back(8'h80);
      send_message();
      push_text("{1{1}a{}");
      send_message();
      push_text("{123456");
      send_message();
      push_text("9{/");
      send_message();
      push_text("}");
      send_message();

      push_text("{65535}");
      repeat (40) message.push_back(8'($urandom_range(0, 255)));
      send_message();

      target = bytes_sent + RANDOM_BYTES;
      while (bytes_sent < target) begin
         repeat ($urandom_range(1, 4)) add_entry();
         cut = $urandom_range(0, 5);
         if (cut == 0) begin
            keep = $urandom_range(1, message.size());
            while (message.size() > keep) void'(message.pop_back());
         end else if (cut == 1) begin
            repeat ($urandom_range(1, 3)) message.push_back(noise_byte());
         end
         send_message();
      end

      req_valid <= 1'b0;
      @(posedge clock);
      while (responses_due != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (mismatch_count == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule

/* filelist.f */
design/lpd_pkg.sv
design/lpd_front.sv
design/lpd_queue.sv
design/lpd_back.sv
design/length_prefixed_deframer_core.sv
dv/length_prefixed_deframer_checker.sv
dv/length_prefixed_deframer_core_tb.sv
